// ===== sv/ppba_pkg.sv =====
package ppba_pkg;

  localparam int MAX_PAGES = 16;
  localparam int SLOT_W    = $clog2(MAX_PAGES);
  localparam int PTR_W     = $clog2(MAX_PAGES + 1);
  localparam int SIZE_W    = 16;
  localparam int OP_W      = 3;
  localparam int FP_W      = 5;
  localparam int ST_W      = 2;

  localparam logic [PTR_W-1:0]  NO_PAGE         = PTR_W'(MAX_PAGES);
  localparam logic [SIZE_W-1:0] PAGE_SIZE_RESET = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0] COUNT_MAX       = '1;

  typedef enum logic [OP_W-1:0] {
    OP_INIT    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_FREE    = 3'd2,
    OP_MARK    = 3'd3,
    OP_RELEASE = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_FULL     = 2'd2,
    ST_ABSENT   = 2'd3
  } status_t;

endpackage

// ===== sv/ppba_if.sv =====
interface ppba_in_if;
  logic                          valid;
  logic                          ready;
  logic [ppba_pkg::OP_W-1:0]     opcode;
  logic [ppba_pkg::SIZE_W-1:0]   req_size;
  logic [ppba_pkg::FP_W-1:0]     free_page;

  modport source (output valid, output opcode, output req_size, output free_page,
                  input ready);
  modport sink   (input valid, input opcode, input req_size, input free_page,
                  output ready);
endinterface

interface ppba_out_if;
  logic                          valid;
  logic                          ready;
  logic [ppba_pkg::ST_W-1:0]     status;
  logic [ppba_pkg::SLOT_W-1:0]   page_slot;
  logic [ppba_pkg::SIZE_W-1:0]   page_offset;

  modport source (output valid, output status, output page_slot, output page_offset,
                  input ready);
  modport sink   (input valid, input status, input page_slot, input page_offset,
                  output ready);
endinterface

// ===== sv/page_pool_bump_allocator_top.sv =====
// channel | dir | handshake       | payload
// in_ch   | in  | valid/ready     | opcode, req_size, free_page
// out_ch  | out | valid/ready     | status, page_slot, page_offset
// cfg     | in  | cfg_wr_en write | cfg_wr_data = page_size
//
// Init, mark, release, unused opcodes, oversize allocate: accept goes straight to the
// finish state, which loads the result. Allocate and free walk one chain slot per cycle,
// allocate through the fit compare; a new item is taken once the result is loaded.
// Synchronous active-low reset: page_size 4096, empty chain, no slots opened.
// A stalled result holds the sequencer in its finish state.
module page_pool_bump_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ppba_pkg::SIZE_W-1:0]   cfg_wr_data,
  ppba_in_if.sink                       in_ch,
  ppba_out_if.source                    out_ch
);
  import ppba_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [SIZE_W-1:0] req_r, req_nxt;
  logic [FP_W-1:0]   fp_r, fp_nxt;
  logic [PTR_W-1:0]  cur_r, cur_nxt;
  logic [PTR_W-1:0]  n_r, n_nxt;
  logic [SIZE_W-1:0] page_size_r;
  logic [PTR_W-1:0]  slots_opened_r, slots_opened_nxt;
  logic [PTR_W-1:0]  chain_head_r, chain_head_nxt;
  logic [PTR_W-1:0]  saved_head_r, saved_head_nxt;
  status_t           res_st_r, res_st_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [SIZE_W-1:0] res_off_r, res_off_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_st_r, out_st_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [SIZE_W-1:0] out_off_r, out_off_nxt;

  logic [SIZE_W-1:0] slot_offset_r     [MAX_PAGES];
  logic [SIZE_W-1:0] slot_live_count_r [MAX_PAGES];
  logic [PTR_W-1:0]  slot_link_r       [MAX_PAGES];

  logic              wr_en;
  logic [SLOT_W-1:0] wr_idx;
  logic [SIZE_W-1:0] wr_off;
  logic [SIZE_W-1:0] wr_cnt;
  logic [PTR_W-1:0]  wr_link;

  logic [SLOT_W-1:0] cur_idx;
  logic [SIZE_W-1:0] off_rd, cnt_rd, cnt_dec;
  logic [PTR_W-1:0]  link_rd;
  logic              fits, walk_end, in_acc;
  logic [SIZE_W-1:0] new_off;

  assign cur_idx = cur_r[SLOT_W-1:0];
  assign off_rd  = slot_offset_r[cur_idx];
  assign cnt_rd  = slot_live_count_r[cur_idx];
  assign link_rd = slot_link_r[cur_idx];
  assign cnt_dec = (cnt_rd != '0) ? cnt_rd - SIZE_W'(1) : '0;

  ppba_fit u_fit (
    .page_size  (page_size_r),
    .offset     (off_rd),
    .req_size   (req_r),
    .fits       (fits),
    .new_offset (new_off)
  );

  assign walk_end = (n_r == PTR_W'(MAX_PAGES)) || (cur_r >= NO_PAGE);

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_acc             = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.page_slot   = out_slot_r;
  assign out_ch.page_offset = out_off_r;

  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    req_nxt          = req_r;
    fp_nxt           = fp_r;
    cur_nxt          = cur_r;
    n_nxt            = n_r;
    slots_opened_nxt = slots_opened_r;
    chain_head_nxt   = chain_head_r;
    saved_head_nxt   = saved_head_r;
    res_st_nxt       = res_st_r;
    res_slot_nxt     = res_slot_r;
    res_off_nxt      = res_off_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_st_nxt       = out_st_r;
    out_slot_nxt     = out_slot_r;
    out_off_nxt      = out_off_r;
    wr_en            = 1'b0;
    wr_idx           = cur_idx;
    wr_off           = off_rd;
    wr_cnt           = cnt_rd;
    wr_link          = link_rd;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt       = op_t'(in_ch.opcode);
          req_nxt      = in_ch.req_size;
          fp_nxt       = in_ch.free_page;
          cur_nxt      = chain_head_r;
          n_nxt        = '0;
          res_st_nxt   = ST_OK;
          res_slot_nxt = '0;
          res_off_nxt  = '0;
          state_nxt    = S_DONE;
          case (op_t'(in_ch.opcode))
            OP_INIT: begin
              slots_opened_nxt = PTR_W'(1);
              chain_head_nxt   = '0;
              wr_en            = 1'b1;
              wr_idx           = '0;
              wr_off           = '0;
              wr_cnt           = '0;
              wr_link          = NO_PAGE;
            end
            OP_ALLOC: begin
              if (in_ch.req_size > page_size_r) begin
                res_st_nxt = ST_OVERSIZE;
              end else begin
                state_nxt = S_WALK;
              end
            end
            OP_FREE:    state_nxt      = S_WALK;
            OP_MARK:    saved_head_nxt = chain_head_r;
            OP_RELEASE: chain_head_nxt = saved_head_r;
            default:    ;
          endcase
        end
      end
      S_WALK: begin
        if (walk_end) begin
          state_nxt = S_DONE;
          if (op_r == OP_ALLOC) begin
            if (slots_opened_r < PTR_W'(MAX_PAGES)) begin
              wr_en            = 1'b1;
              wr_idx           = slots_opened_r[SLOT_W-1:0];
              wr_off           = req_r;
              wr_cnt           = SIZE_W'(1);
              wr_link          = chain_head_r;
              chain_head_nxt   = slots_opened_r;
              slots_opened_nxt = slots_opened_r + PTR_W'(1);
              res_st_nxt       = ST_OK;
              res_slot_nxt     = slots_opened_r[SLOT_W-1:0];
            end else begin
              res_st_nxt = ST_FULL;
            end
          end else begin
            res_st_nxt = ST_ABSENT;
          end
        end else if (op_r == OP_ALLOC) begin
          if (fits) begin
            wr_en        = 1'b1;
            wr_off       = new_off;
            wr_cnt       = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + SIZE_W'(1);
            res_slot_nxt = cur_idx;
            res_off_nxt  = off_rd;
            state_nxt    = S_DONE;
          end else begin
            cur_nxt = link_rd;
            n_nxt   = n_r + PTR_W'(1);
          end
        end else begin
          if (cur_r == PTR_W'(fp_r)) begin
            wr_en        = 1'b1;
            wr_cnt       = cnt_dec;
            wr_off       = (cnt_dec == '0) ? '0 : off_rd;
            res_slot_nxt = cur_idx;
            state_nxt    = S_DONE;
          end else begin
            cur_nxt = link_rd;
            n_nxt   = n_r + PTR_W'(1);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_slot_nxt  = res_slot_r;
          out_off_nxt   = res_off_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      page_size_r    <= PAGE_SIZE_RESET;
      slots_opened_r <= '0;
      chain_head_r   <= NO_PAGE;
      saved_head_r   <= NO_PAGE;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      if (cfg_wr_en) begin
        page_size_r <= cfg_wr_data;
      end
      slots_opened_r <= slots_opened_nxt;
      chain_head_r   <= chain_head_nxt;
      saved_head_r   <= saved_head_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    req_r      <= req_nxt;
    fp_r       <= fp_nxt;
    cur_r      <= cur_nxt;
    n_r        <= n_nxt;
    res_st_r   <= res_st_nxt;
    res_slot_r <= res_slot_nxt;
    res_off_r  <= res_off_nxt;
    out_st_r   <= out_st_nxt;
    out_slot_r <= out_slot_nxt;
    out_off_r  <= out_off_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_offset_r[wr_idx]     <= wr_off;
      slot_live_count_r[wr_idx] <= wr_cnt;
      slot_link_r[wr_idx]       <= wr_link;
    end
  end

endmodule

// ===== sv/ppba_fit.sv =====
module ppba_fit (
  input  logic [ppba_pkg::SIZE_W-1:0] page_size,
  input  logic [ppba_pkg::SIZE_W-1:0] offset,
  input  logic [ppba_pkg::SIZE_W-1:0] req_size,
  output logic                        fits,
  output logic [ppba_pkg::SIZE_W-1:0] new_offset
);
  import ppba_pkg::*;

  logic [SIZE_W-1:0] room;

  // room is only meaningful while offset < page_size
  assign room       = page_size - offset;
  assign fits       = (offset < page_size) && (room > req_size);
  assign new_offset = offset + req_size;

endmodule

// ===== sv/ppba_checker.sv =====
module ppba_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ppba_pkg::ST_W-1:0]   out_status,
  input logic [ppba_pkg::SLOT_W-1:0] out_page_slot,
  input logic [ppba_pkg::SIZE_W-1:0] out_page_offset
);
  import ppba_pkg::*;

  // one item in flight: accept drops ready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after an item was accepted");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_page_slot == '0) && (out_page_offset == '0))
    else $error("failing result carries nonzero slot or offset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_page_slot)
                                && $stable(out_page_offset))
    else $error("stalled result changed");

endmodule

bind page_pool_bump_allocator_top ppba_checker u_ppba_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_page_slot   (out_ch.page_slot),
  .out_page_offset (out_ch.page_offset)
);

// ===== test/page_pool_bump_allocator_top_tb.sv =====
module page_pool_bump_allocator_top_tb;
  import ppba_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 48;
  localparam int NUM_PHASES   = 7;
  localparam int BURST_ALLOCS = 40;
  localparam int NUM_ROWS     = 26;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] offset;
  } pool_reply_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] req;
    logic [FP_W-1:0]   fp;
    logic              typed;
    logic [ST_W-1:0]   status;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] offset;
  } dir_row_t;

  typedef struct packed {
    logic        typed;
    pool_reply_t want;
  } hint_t;

  // typed rows: reply read off directly; others come from the pool predictor
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{OP_RELEASE, 16'd0,     5'd0,  1'b1, ST_OK,       4'd0, 16'd0},
    '{OP_FREE,    16'd0,     5'd0,  1'b1, ST_ABSENT,   4'd0, 16'd0},
    '{OP_ALLOC,   16'd0,     5'd0,  1'b1, ST_OK,       4'd0, 16'd0},
    '{OP_INIT,    16'd0,     5'd0,  1'b1, ST_OK,       4'd0, 16'd0},
    '{OP_ALLOC,   16'd65535, 5'd0,  1'b1, ST_OVERSIZE, 4'd0, 16'd0},
    '{OP_ALLOC,   16'd4097,  5'd0,  1'b1, ST_OVERSIZE, 4'd0, 16'd0},
    '{OP_ALLOC,   16'd4096,  5'd0,  1'b0, ST_OK,       4'd0, 16'd0},
    '{OP_ALLOC,   16'd4095,  5'd0,  1'b0, ST_OK,       4'd0, 16'd0},
    '{OP_ALLOC,   16'd0,     5'd0,  1'b0, ST_OK,       4'd0, 16'd0},
    '{OP_ALLOC,   16'd1,     5'd0,  1'b0, ST_OK,       4'd0, 16'd0},
    '{OP_MARK,    16'd0,     5'd0,  1'b1, ST_OK,       4'd0, 16'd0},
    '{OP_ALLOC,   16'd4096,  5'd0,  1'b0, ST_OK,       4'd0, 16'd0},
    '{OP_FREE,    16'd0,     5'd3,  1'b0, ST_OK,       4'd0, 16'd0},
    '{OP_RELEASE, 16'd0,     5'd0,  1'b1, ST_OK,       4'd0, 16'd0},
    '{OP_FREE,    16'd0,     5'd3,  1'b1, ST_ABSENT,   4'd0, 16'd0},
    '{OP_FREE,    16'd0,     5'd31, 1'b1, ST_ABSENT,   4'd0, 16'd0},
    '{OP_FREE,    16'd0,     5'd16, 1'b1, ST_ABSENT,   4'd0, 16'd0},
    '{OP_FREE,    16'd0,     5'd0,  1'b0, ST_OK,       4'd0, 16'd0},
    '{OP_FREE,    16'd0,     5'd0,  1'b0, ST_OK,       4'd0, 16'd0},
    '{OP_FREE,    16'd0,     5'd0,  1'b0, ST_OK,       4'd0, 16'd0},
    '{OP_ALLOC,   16'd100,   5'd0,  1'b0, ST_OK,       4'd0, 16'd0},
    '{OP_SPARE_LO, 16'd65535, 5'd31, 1'b1, ST_OK,      4'd0, 16'd0},
    '{OP_SPARE_HI, 16'd0,    5'd0,  1'b1, ST_OK,       4'd0, 16'd0},
    '{OP_INIT,    16'd0,     5'd0,  1'b1, ST_OK,       4'd0, 16'd0},
    '{OP_RELEASE, 16'd0,     5'd0,  1'b1, ST_OK,       4'd0, 16'd0},
    '{OP_ALLOC,   16'd0,     5'd0,  1'b0, ST_OK,       4'd0, 16'd0}
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [SIZE_W-1:0] cfg_wr_data;

  ppba_in_if  in_ch ();
  ppba_out_if out_ch ();

  page_pool_bump_allocator_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // pool predictor state
  logic [SIZE_W-1:0] pool_page_size;
  logic [SIZE_W-1:0] pool_offset [MAX_PAGES];
  logic [SIZE_W-1:0] pool_count  [MAX_PAGES];
  logic [PTR_W-1:0]  pool_link   [MAX_PAGES];
  logic [PTR_W-1:0]  pool_opened;
  logic [PTR_W-1:0]  pool_head;
  logic [PTR_W-1:0]  pool_mark;

  pool_reply_t       reply_q [$];
  hint_t             hint_q [$];
  int                mismatches;
  int                idle_cycles;
  bit                quiet;
  logic [SIZE_W-1:0] stim_page_size;

  function automatic logic [PTR_W-1:0] open_slot(input logic [SIZE_W-1:0] first_off,
                                                 input logic [SIZE_W-1:0] first_cnt);
    logic [PTR_W-1:0] s;
    s = pool_opened;
    if (s >= MAX_PAGES) return NO_PAGE;
    pool_offset[s[SLOT_W-1:0]] = first_off;
    pool_count[s[SLOT_W-1:0]]  = first_cnt;
    pool_link[s[SLOT_W-1:0]]   = pool_head;
    pool_head   = s;
    pool_opened = s + 1'b1;
    return s;
  endfunction

  function automatic pool_reply_t pool_apply(input logic [OP_W-1:0] op,
                                             input logic [SIZE_W-1:0] req,
                                             input logic [FP_W-1:0] fp);
    pool_reply_t       r;
    logic [PTR_W-1:0]  cur;
    logic [PTR_W-1:0]  s;
    logic [SIZE_W-1:0] off;
    r = '0;
    case (op)
      OP_INIT: begin
        pool_opened = '0;
        pool_head   = NO_PAGE;
        s = open_slot('0, '0);
        r.slot = s[SLOT_W-1:0];
      end
      OP_ALLOC: begin
        if (req > pool_page_size) begin
          r.status = ST_OVERSIZE;
          return r;
        end
        cur = pool_head;
        for (int n = 0; n < MAX_PAGES && cur < MAX_PAGES; n++) begin
          off = pool_offset[cur[SLOT_W-1:0]];
          if (off < pool_page_size && (pool_page_size - off) > req) begin
            pool_offset[cur[SLOT_W-1:0]] = off + req;
            if (pool_count[cur[SLOT_W-1:0]] != COUNT_MAX)
              pool_count[cur[SLOT_W-1:0]] = pool_count[cur[SLOT_W-1:0]] + 1'b1;
            r.slot   = cur[SLOT_W-1:0];
            r.offset = off;
            return r;
          end
          cur = pool_link[cur[SLOT_W-1:0]];
        end
        s = open_slot(req, 16'd1);
        if (s == NO_PAGE) r.status = ST_FULL;
        else r.slot = s[SLOT_W-1:0];
      end
      OP_FREE: begin
        cur = pool_head;
        for (int n = 0; n < MAX_PAGES && cur < MAX_PAGES; n++) begin
          if (cur == fp) begin
            if (pool_count[cur[SLOT_W-1:0]] != '0)
              pool_count[cur[SLOT_W-1:0]] = pool_count[cur[SLOT_W-1:0]] - 1'b1;
            if (pool_count[cur[SLOT_W-1:0]] == '0)
              pool_offset[cur[SLOT_W-1:0]] = '0;
            r.slot = cur[SLOT_W-1:0];
            return r;
          end
          cur = pool_link[cur[SLOT_W-1:0]];
        end
        r.status = ST_ABSENT;
      end
      OP_MARK: pool_mark = pool_head;
      OP_RELEASE: pool_head = pool_mark;
      default: ;
    endcase
    return r;
  endfunction

  // predictor, scoreboard and watchdog
  always @(posedge clk) begin
    pool_reply_t want;
    hint_t       h;
    bit          moved;
    if (!rst_n) begin
      pool_page_size = PAGE_SIZE_RESET;
      pool_opened    = '0;
      pool_head      = NO_PAGE;
      pool_mark      = NO_PAGE;
      for (int i = 0; i < MAX_PAGES; i++) begin
        pool_offset[i] = '0;
        pool_count[i]  = '0;
        pool_link[i]   = '0;
      end
    end else begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        h = hint_q.pop_front();
        want = pool_apply(in_ch.opcode, in_ch.req_size, in_ch.free_page);
        reply_q.push_back(h.typed ? h.want : want);
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (reply_q.size() == 0) begin
          $error("result with no item pending: status %0d slot %0d offset %0d",
                 out_ch.status, out_ch.page_slot, out_ch.page_offset);
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.page_slot !== want.slot) begin
            $error("page_slot: expected %0d, got %0d", want.slot, out_ch.page_slot);
            mismatches++;
          end
          if (out_ch.page_offset !== want.offset) begin
            $error("page_offset: expected %0d, got %0d", want.offset, out_ch.page_offset);
            mismatches++;
          end
        end
      end
      if (cfg_wr_en) pool_page_size = cfg_wr_data;
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) out_ch.ready <= quiet || ($urandom_range(99) >= 8);

  task automatic send_item(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] req,
                           input logic [FP_W-1:0] fp, input logic typed,
                           input pool_reply_t want);
    if (!quiet && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    hint_q.push_back('{typed, want});
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.req_size  <= req;
    in_ch.free_page <= fp;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_for_replies();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_page_size(input logic [SIZE_W-1:0] v);
    wait_for_replies();
    stim_page_size = v;
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic pick_item(output logic [OP_W-1:0] op, output logic [SIZE_W-1:0] req,
                           output logic [FP_W-1:0] fp);
    int p;
    int k;
    p = $urandom_range(99);
    k = $urandom_range(9);
    if (p < 50) op = OP_ALLOC;
    else if (p < 75) op = OP_FREE;
    else if (p < 82) op = OP_MARK;
    else if (p < 89) op = OP_RELEASE;
    else if (p < 95) op = OP_INIT;
    else op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    if (k < 6) req = SIZE_W'($urandom_range(0, stim_page_size / 4));
    else if (k < 8) req = SIZE_W'($urandom_range(0, stim_page_size));
    else if (k == 8) req = SIZE_W'(int'(stim_page_size) + $urandom_range(0, 2) - 1);
    else req = SIZE_W'($urandom());
    if ($urandom_range(9) == 0) fp = FP_W'($urandom_range(16, 31));
    else fp = FP_W'($urandom_range(0, MAX_PAGES - 1));
  endtask

  initial begin
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] req;
    logic [FP_W-1:0]   fp;
    logic [SIZE_W-1:0] sizes [NUM_PHASES];
    mismatches      = 0;
    idle_cycles     = 0;
    quiet           = 1'b0;
    stim_page_size  = PAGE_SIZE_RESET;
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= PAGE_SIZE_RESET;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= OP_INIT;
    in_ch.req_size  <= '0;
    in_ch.free_page <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++)
      send_item(DIR_ROWS[i].op, DIR_ROWS[i].req, DIR_ROWS[i].fp, DIR_ROWS[i].typed,
                '{DIR_ROWS[i].status, DIR_ROWS[i].slot, DIR_ROWS[i].offset});

    // a big page filled first, then shrunk without init to force overrun
    sizes[0] = 16'd1;
    sizes[1] = 16'd65535;
    sizes[2] = SIZE_W'($urandom_range(16, 600));
    sizes[3] = 16'd4096;
    sizes[4] = SIZE_W'($urandom_range(1, 65535));
    sizes[5] = 16'd2;
    sizes[6] = SIZE_W'($urandom_range(100, 2000));
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_page_size(sizes[ph]);
      if (ph == 0) send_item(OP_INIT, '0, '0, 1'b0, '0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == 25) wait_for_replies();
        pick_item(op, req, fp);
        send_item(op, req, fp, 1'b0, '0);
      end
    end

    // one page hit over and over, run back to back with no idling
    set_page_size(16'd65535);
    quiet = 1'b1;
    send_item(OP_INIT, '0, '0, 1'b0, '0);
    send_item(OP_ALLOC, 16'd5, '0, 1'b0, '0);
    for (int i = 0; i < BURST_ALLOCS; i++)
      send_item(OP_ALLOC, '0, FP_W'($urandom_range(0, 31)), 1'b0, '0);
    send_item(OP_FREE, '0, 5'd0, 1'b0, '0);
    send_item(OP_ALLOC, '0, '0, 1'b0, '0);
    quiet = 1'b0;

    wait_for_replies();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
